### sv/sorted_event_queue_macros.svh
// ----------------------------------------------------------------------------
// sorted event queue assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i and off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_EVENT_QUEUE_MACROS_SVH
`define SORTED_EVENT_QUEUE_MACROS_SVH

// property that holds at every clock edge out of reset
`define SEQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property whose consequence holds in the cycle after its condition
`define SEQ_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

### sv/seq_pkg.sv
// ----------------------------------------------------------------------------
// seq_pkg
// Types and constants shared by the sorted event queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package seq_pkg;

  // fixed field widths of the channel payload
  localparam int unsigned OpW       = 2;
  localparam int unsigned IdFieldW  = 16;
  localparam int unsigned TickW     = 30;
  localparam int unsigned TagFieldW = 16;
  localparam int unsigned StatusW   = 3;

  // operation codes
  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_EVAL   = 2'd2
  } op_e;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_FIRED    = 3'd1,
    ST_IDLE     = 3'd2,
    ST_BEHIND   = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2,
    CELL_REMOVE = 2'd3
  } cell_op_e;

  // controller states
  typedef enum logic {
    CTRL_IDLE   = 1'b0,
    CTRL_DELETE = 1'b1
  } ctrl_state_e;

  // input item
  typedef struct packed {
    logic [OpW-1:0]       operation;
    logic [IdFieldW-1:0]  entry_id;
    logic [TickW-1:0]     event_tick;
    logic [TagFieldW-1:0] event_tag;
  } seq_in_t;

  // result item
  typedef struct packed {
    logic [StatusW-1:0]   status;
    logic [IdFieldW-1:0]  fired_id;
    logic [TickW-1:0]     fired_tick;
    logic [TagFieldW-1:0] fired_tag;
  } seq_out_t;

  // command from controller to the cell chain
  typedef struct packed {
    cell_op_e         op;
    logic [TickW-1:0] tick;
  } seq_ctl_t;

  // chain status seen by the controller
  typedef struct packed {
    logic head_valid;
    logic head_lt;
    logic tail_valid;
    logic any_match;
  } seq_sts_t;

endpackage

`default_nettype wire

### sv/seq_ifs.sv
// ----------------------------------------------------------------------------
// seq channel interfaces
// Valid/ready channels carrying queue requests and queue results.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel
interface seq_in_if import seq_pkg::*; ();
  logic    valid;
  logic    ready;
  seq_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// result channel
interface seq_out_if import seq_pkg::*; ();
  logic     valid;
  logic     ready;
  seq_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/seq_cell.sv
// ----------------------------------------------------------------------------
// seq_cell
// One slot of the sorted chain: holds one event and trades it with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module seq_cell import seq_pkg::*; #(
  parameter int unsigned ID_W  = 16,
  parameter int unsigned TAG_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire seq_ctl_t         ctl_i,
  input  wire logic [ID_W-1:0]  new_id_i,
  input  wire logic [TAG_W-1:0] new_tag_i,
  input  wire logic             left_lt_i,
  input  wire logic             left_valid_i,
  input  wire logic [ID_W-1:0]  left_id_i,
  input  wire logic [TickW-1:0] left_tick_i,
  input  wire logic [TAG_W-1:0] left_tag_i,
  input  wire logic             right_valid_i,
  input  wire logic [ID_W-1:0]  right_id_i,
  input  wire logic [TickW-1:0] right_tick_i,
  input  wire logic [TAG_W-1:0] right_tag_i,
  input  wire logic             match_left_i,
  output logic                  valid_o,
  output logic [ID_W-1:0]       id_o,
  output logic [TickW-1:0]      tick_o,
  output logic [TAG_W-1:0]      tag_o,
  output logic                  lt_o,
  output logic                  match_o
);

  logic             valid_q, valid_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [TAG_W-1:0] tag_q, tag_d;

  // local compares: stays ahead of a new event, id hit for delete
  assign lt_o    = valid_q && (tick_q < ctl_i.tick);
  assign match_o = match_left_i || (valid_q && (id_q == new_id_i));

  // slot update
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    tick_d  = tick_q;
    tag_d   = tag_q;
    unique case (ctl_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        priority if (lt_o) begin
        end else if (left_lt_i) begin
          valid_d = 1'b1;
          id_d    = new_id_i;
          tick_d  = ctl_i.tick;
          tag_d   = new_tag_i;
        end else begin
          valid_d = left_valid_i;
          id_d    = left_id_i;
          tick_d  = left_tick_i;
          tag_d   = left_tag_i;
        end
      end
      CELL_POP: begin
        valid_d = right_valid_i;
        id_d    = right_id_i;
        tick_d  = right_tick_i;
        tag_d   = right_tag_i;
      end
      CELL_REMOVE: begin
        if (match_o) begin
          valid_d = right_valid_i;
          id_d    = right_id_i;
          tick_d  = right_tick_i;
          tag_d   = right_tag_i;
        end
      end
    endcase
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // event payload
  always_ff @(posedge clk_i) begin
    id_q   <= id_d;
    tick_q <= tick_d;
    tag_q  <= tag_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign tick_o  = tick_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

### sv/seq_ctrl.sv
// ----------------------------------------------------------------------------
// seq_ctrl
// Request decode, cursor tracking, delete sequencing and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_event_queue_macros.svh"

module seq_ctrl import seq_pkg::*; #(
  parameter int unsigned ID_W  = 16,
  parameter int unsigned TAG_W = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  seq_in_if.sink                in_ch,
  seq_out_if.source             out_ch,
  input  wire seq_sts_t         sts_i,
  input  wire logic [ID_W-1:0]  head_id_i,
  input  wire logic [TickW-1:0] head_tick_i,
  input  wire logic [TAG_W-1:0] head_tag_i,
  output seq_ctl_t              ctl_o,
  output logic [ID_W-1:0]       new_id_o,
  output logic [TAG_W-1:0]      new_tag_o
);

  ctrl_state_e     state_q, state_d;
  logic            at_start_q, at_start_d;
  logic [ID_W-1:0] del_id_q, del_id_d;
  logic            out_valid_q, out_valid_d;
  seq_out_t        out_q, out_d;
  logic            out_load;
  logic            in_ready;
  logic            accept;
  logic            is_delete;

  assign accept    = in_ch.valid && in_ready;
  assign is_delete = (in_ch.data.operation == OP_DELETE);

  // key and payload offered to the chain
  assign new_id_o  = (state_q == CTRL_DELETE) ? del_id_q : in_ch.data.entry_id[ID_W-1:0];
  assign new_tag_o = in_ch.data.event_tag[TAG_W-1:0];
  assign del_id_d  = (accept && is_delete) ? in_ch.data.entry_id[ID_W-1:0] : del_id_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_IDLE: begin
        if (accept && is_delete && sts_i.any_match) begin
          state_d = CTRL_DELETE;
        end
      end
      CTRL_DELETE: begin
        if (!sts_i.any_match && (!out_valid_q || out_ch.ready)) begin
          state_d = CTRL_IDLE;
        end
      end
    endcase
  end

  // outputs: chain command, cursor and result
  always_comb begin
    in_ready   = 1'b0;
    ctl_o.op   = CELL_HOLD;
    ctl_o.tick = in_ch.data.event_tick;
    at_start_d = at_start_q;
    out_load   = 1'b0;
    out_d      = '0;
    out_d.status = ST_IDLE;
    unique case (state_q)
      CTRL_IDLE: begin
        in_ready = !out_valid_q || out_ch.ready;
        if (accept) begin
          out_load = 1'b1;
          unique case (in_ch.data.operation)
            OP_ADD: begin
              priority if (!at_start_q && !sts_i.head_lt) begin
                out_d.status = ST_BEHIND;
              end else if (sts_i.tail_valid) begin
                out_d.status = ST_FULL;
              end else begin
                ctl_o.op     = CELL_INSERT;
                out_d.status = ST_ACCEPTED;
              end
            end
            OP_DELETE: begin
              ctl_o.op     = CELL_REMOVE;
              out_load     = !sts_i.any_match;
              out_d.status = ST_ACCEPTED;
            end
            OP_EVAL: begin
              priority if (at_start_q) begin
                at_start_d = 1'b0;
              end else if (sts_i.head_valid) begin
                ctl_o.op         = CELL_POP;
                out_d.status     = ST_FIRED;
                out_d.fired_id   = IdFieldW'(head_id_i);
                out_d.fired_tick = head_tick_i;
                out_d.fired_tag  = TagFieldW'(head_tag_i);
              end else begin
              end
            end
            default: begin
            end
          endcase
        end
      end
      CTRL_DELETE: begin
        // one matching entry leaves per cycle until none is left, then the
        // result waits for the result register to be free
        ctl_o.op = CELL_REMOVE;
        if (!sts_i.any_match && (!out_valid_q || out_ch.ready)) begin
          out_load     = 1'b1;
          out_d.status = ST_ACCEPTED;
        end
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ch.ready);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_IDLE;
      at_start_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      at_start_q  <= at_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    del_id_q <= del_id_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  `SEQ_ASSERT(a_out_no_overwrite, out_load |-> (!out_valid_q || out_ch.ready), "result lost")
  `SEQ_ASSERT(a_pop_needs_head, (ctl_o.op == CELL_POP) |-> sts_i.head_valid, "pop on empty")
  `SEQ_ASSERT(a_insert_not_full, (ctl_o.op == CELL_INSERT) |-> !sts_i.tail_valid, "insert when full")
  `SEQ_ASSERT_NEXT(a_start_sticky, !at_start_q, !at_start_q, "start marker came back")

endmodule

`default_nettype wire

### sv/sorted_event_queue.sv
// ----------------------------------------------------------------------------
// sorted_event_queue
// Tick-ordered event queue built from a chain of shifting cells.
// ----------------------------------------------------------------------------
// Requests arrive on in_ch (add, delete by id, evaluate); every request gives
// exactly one result on out_ch with a status and, for a fired event, its id,
// tick and tag. Both channels transfer when valid and ready are high.
// For add, evaluate and an unused code the result is registered and shown in
// the cycle after the transfer. A delete sweeps the chain one matching entry
// per cycle and then waits while an earlier result is still held on a
// stalled out_ch; in_ch.ready is low meanwhile. Sustained rate is one request
// per cycle for add and evaluate while out_ch does not stall.
// The result register lets a new request in during the cycle its result is
// taken; while out_ch stalls with a result held, in_ch.ready stays low.
// Reset empties the chain and puts the cursor back on the start marker.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_event_queue_macros.svh"

module sorted_event_queue import seq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 16,
  parameter int unsigned TAG_BITS    = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  seq_in_if.sink    in_ch,
  seq_out_if.source out_ch
);

  localparam int unsigned IdW  = (ID_BITS < IdFieldW) ? ID_BITS : IdFieldW;
  localparam int unsigned TagW = (TAG_BITS < TagFieldW) ? TAG_BITS : TagFieldW;

  seq_ctl_t        ctl;
  seq_sts_t        sts;
  logic [IdW-1:0]  new_id;
  logic [TagW-1:0] new_tag;

  logic [QUEUE_DEPTH-1:0] vld;
  logic [QUEUE_DEPTH-1:0] lt;
  logic [QUEUE_DEPTH-1:0] mt;
  logic [IdW-1:0]         cid  [QUEUE_DEPTH];
  logic [TickW-1:0]       ctk  [QUEUE_DEPTH];
  logic [TagW-1:0]        ctg  [QUEUE_DEPTH];

  // controller
  seq_ctrl #(
    .ID_W  (IdW),
    .TAG_W (TagW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .sts_i       (sts),
    .head_id_i   (cid[0]),
    .head_tick_i (ctk[0]),
    .head_tag_i  (ctg[0]),
    .ctl_o       (ctl),
    .new_id_o    (new_id),
    .new_tag_o   (new_tag)
  );

  // chain status
  assign sts.head_valid = vld[0];
  assign sts.head_lt    = lt[0];
  assign sts.tail_valid = vld[QUEUE_DEPTH-1];
  assign sts.any_match  = mt[QUEUE_DEPTH-1];

  // cell chain, head at index zero
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic             l_lt, l_vld, r_vld, m_in;
    logic [IdW-1:0]   l_id, r_id;
    logic [TickW-1:0] l_tk, r_tk;
    logic [TagW-1:0]  l_tg, r_tg;

    if (k == 0) begin : g_first
      assign l_lt  = 1'b1;
      assign l_vld = 1'b0;
      assign l_id  = '0;
      assign l_tk  = '0;
      assign l_tg  = '0;
      assign m_in  = 1'b0;
    end else begin : g_mid
      assign l_lt  = lt[k-1];
      assign l_vld = vld[k-1];
      assign l_id  = cid[k-1];
      assign l_tk  = ctk[k-1];
      assign l_tg  = ctg[k-1];
      assign m_in  = mt[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign r_vld = 1'b0;
      assign r_id  = '0;
      assign r_tk  = '0;
      assign r_tg  = '0;
    end else begin : g_inner
      assign r_vld = vld[k+1];
      assign r_id  = cid[k+1];
      assign r_tk  = ctk[k+1];
      assign r_tg  = ctg[k+1];
    end

    seq_cell #(
      .ID_W  (IdW),
      .TAG_W (TagW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .new_id_i      (new_id),
      .new_tag_i     (new_tag),
      .left_lt_i     (l_lt),
      .left_valid_i  (l_vld),
      .left_id_i     (l_id),
      .left_tick_i   (l_tk),
      .left_tag_i    (l_tg),
      .right_valid_i (r_vld),
      .right_id_i    (r_id),
      .right_tick_i  (r_tk),
      .right_tag_i   (r_tg),
      .match_left_i  (m_in),
      .valid_o       (vld[k]),
      .id_o          (cid[k]),
      .tick_o        (ctk[k]),
      .tag_o         (ctg[k]),
      .lt_o          (lt[k]),
      .match_o       (mt[k])
    );
  end

  `SEQ_ASSERT(a_valid_prefix, ((vld & (vld + 1'b1)) == '0), "hole in the chain")

endmodule

`default_nettype wire
